// ===== rtl/core/lps_pkg.sv =====
// shared types, constants and helpers of the letter permutation swap table
package lps_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef enum logic {
    OP_SWAP  = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_XLATE
  } state_t;

  // one write into a table
  typedef struct packed {
    logic en;
    idx_t addr;
    idx_t data;
  } tbl_wr_t;

  function automatic logic letter_ok(letter_t l);
    return int'(l) < ALPHABET_SIZE;
  endfunction

  // out-of-range codes map to entry zero so no access leaves the table
  function automatic idx_t to_idx(letter_t l);
    letter_t clamped;
    clamped = letter_ok(l) ? l : '0;
    return IDX_W'(clamped);
  endfunction

endpackage

// ===== rtl/core/lps_if.sv =====
// valid/ready channel interfaces for letter items and translate results
interface lps_in_if;
  import lps_pkg::*;

  logic    valid;
  logic    ready;
  logic    op;
  letter_t letter_a;
  letter_t letter_b;

  modport source (output valid, output op, output letter_a, output letter_b, input ready);
  modport sink   (input valid, input op, input letter_a, input letter_b, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;

  logic    valid;
  logic    ready;
  letter_t letter_out;
  logic    invalid;

  modport source (output valid, output letter_out, output invalid, input ready);
  modport sink   (input valid, input letter_out, input invalid, output ready);
endinterface

// ===== rtl/core/letter_permutation_swap_table.sv =====
// top level: permutation table with inverse, swap and translate sequencer
//
//  channel  | dir | beat contents                  | handshake
//  ---------+-----+--------------------------------+------------
//  in_ch    | in  | op, letter_a, letter_b         | valid/ready
//  out_ch   | out | letter_out, invalid            | valid/ready
//
// a swap steps through accept, read pos[b] and two write states, one read
// port per table ram; an ignored swap (bad code or same letter) ends at accept
// a translate is an accept plus the registered ram read
// reset clears the written bits of both tables at once, no clearing pass
// swaps go on while a result waits; a translate holds in its read state
// while the result register is full
module letter_permutation_swap_table (
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_ch,
  lps_out_if.source out_ch
);
  import lps_pkg::*;

  state_t  state_r, state_nxt;
  idx_t    a_r, a_nxt;
  idx_t    b_r, b_nxt;
  logic    a_ok_r, a_ok_nxt;
  idx_t    pa_r, pa_nxt;

  logic    out_valid_r, out_valid_nxt;
  letter_t out_letter_r, out_letter_nxt;
  logic    out_inv_r, out_inv_nxt;

  // sequencer outputs
  logic    in_ready;
  logic    out_load;
  tbl_wr_t sub_wr;
  tbl_wr_t pos_wr;
  idx_t    sub_rd_addr;
  idx_t    pos_rd_addr;
  idx_t    sub_rd_data;
  idx_t    pos_rd_data;

  logic    in_acc;
  logic    swap_go;
  logic    out_free;

  assign in_acc   = in_ch.valid && in_ready;
  assign swap_go  = (in_ch.op == OP_SWAP) && letter_ok(in_ch.letter_a)
                    && letter_ok(in_ch.letter_b) && (in_ch.letter_a != in_ch.letter_b);
  assign out_free = !out_valid_r || out_ch.ready;

  // substitute_of: entry p holds the letter sitting at position p
  lps_table u_sub (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (sub_wr),
    .rd_addr (sub_rd_addr),
    .rd_data (sub_rd_data)
  );

  // position_of: entry l holds the position of letter l
  lps_table u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pos_wr),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OP_XLATE) begin
            state_nxt = ST_XLATE;
          end else if (swap_go) begin
            state_nxt = ST_RD_B;
          end
        end
      end
      ST_RD_B:  state_nxt = ST_WR_A;
      ST_WR_A:  state_nxt = ST_WR_B;
      ST_WR_B:  state_nxt = ST_IDLE;
      ST_XLATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    sub_wr      = '0;
    pos_wr      = '0;
    sub_rd_addr = a_r;
    pos_rd_addr = a_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        sub_rd_addr = to_idx(in_ch.letter_a);
        pos_rd_addr = to_idx(in_ch.letter_a);
      end
      ST_RD_B: begin
        // pos[a] is on the read data, fetch pos[b]
        pos_rd_addr = b_r;
      end
      ST_WR_A: begin
        // pos[b] is on the read data now, keep it there for the second write
        pos_rd_addr = b_r;
        pos_wr.en   = 1'b1;
        pos_wr.addr = a_r;
        pos_wr.data = pos_rd_data;
        sub_wr.en   = 1'b1;
        sub_wr.addr = pa_r;
        sub_wr.data = b_r;
      end
      ST_WR_B: begin
        pos_wr.en   = 1'b1;
        pos_wr.addr = b_r;
        pos_wr.data = pa_r;
        sub_wr.en   = 1'b1;
        sub_wr.addr = pos_rd_data;
        sub_wr.data = a_r;
      end
      ST_XLATE: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // item and position capture
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    a_ok_nxt = a_ok_r;
    pa_nxt   = pa_r;
    if (in_acc) begin
      a_nxt    = to_idx(in_ch.letter_a);
      b_nxt    = to_idx(in_ch.letter_b);
      a_ok_nxt = letter_ok(in_ch.letter_a);
    end
    if (state_r == ST_RD_B) begin
      pa_nxt = pos_rd_data;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_letter_nxt = out_letter_r;
    out_inv_nxt    = out_inv_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_letter_nxt = a_ok_r ? LETTER_W'(sub_rd_data) : '0;
      out_inv_nxt    = !a_ok_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    a_ok_r       <= a_ok_nxt;
    pa_r         <= pa_nxt;
    out_letter_r <= out_letter_nxt;
    out_inv_r    <= out_inv_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.letter_out = out_letter_r;
  assign out_ch.invalid    = out_inv_r;

`ifndef ASSERT_OFF
  // tables are only written in the two swap write cycles
  a_wr_only_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_wr.en || pos_wr.en) |-> (state_r == ST_WR_A || state_r == ST_WR_B))
    else $error("table write outside swap write cycles");

  // an accepted translate goes to the read state
  a_xlate_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.op == OP_XLATE) |=> (state_r == ST_XLATE))
    else $error("translate did not enter read state");

  // the second swap write always follows the first
  a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR_A) |=> (state_r == ST_WR_B))
    else $error("swap write sequence broken");

  // a result only appears after a translate read
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_XLATE))
    else $error("result without translate");

  // an invalid result carries letter zero
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_letter_r == '0))
    else $error("invalid result with nonzero letter");
`endif

endmodule

// ===== rtl/core/lps_ram.sv =====
// generic single-write single-read ram with registered read data
module lps_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/lps_table.sv =====
// identity-initialized table: ram plus per-entry written bits
module lps_table (
  input  logic             clk,
  input  logic             rst_n,
  input  lps_pkg::tbl_wr_t wr,
  input  lps_pkg::idx_t    rd_addr,
  output lps_pkg::idx_t    rd_data
);
  import lps_pkg::*;

  logic [ALPHABET_SIZE-1:0] vld_r;
  logic [ALPHABET_SIZE-1:0] vld_nxt;
  logic                     rd_vld_r;
  idx_t                     rd_addr_r;
  idx_t                     ram_q;

  lps_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r  <= vld_r[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // unwritten entries read as their own index
  assign rd_data = rd_vld_r ? ram_q : rd_addr_r;

endmodule

// ===== verif/letter_permutation_swap_table_checker.sv =====
// checker: tracks the letter tables and compares every translate result
module letter_permutation_swap_table_checker (
  input  logic clk,
  input  logic rst_n,
  lps_in_if    in_ch,
  lps_out_if   out_ch,
  output int   fail_count,
  output int   results_pending,
  output int   swaps_seen,
  output int   xlates_seen,
  output int   results_checked
);
  import lps_pkg::*;

  typedef struct {
    letter_t letter;
    logic    invalid;
  } xlate_result_t;

  localparam int MAX_PRINTS = 20;

  letter_t       subst_tbl [ALPHABET_SIZE];
  letter_t       pos_tbl   [ALPHABET_SIZE];
  xlate_result_t pending_xlates [$];
  xlate_result_t want;

  initial begin
    fail_count      = 0;
    results_pending = 0;
    swaps_seen      = 0;
    xlates_seen     = 0;
    results_checked = 0;
  end

  task automatic report(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // exchange two letter values wherever they sit in the substitution table
  function automatic void apply_swap(input letter_t a, input letter_t b);
    letter_t pa;
    letter_t pb;
    letter_t held;
    if (int'(a) >= ALPHABET_SIZE || int'(b) >= ALPHABET_SIZE || a == b) begin
      return;
    end
    pa = pos_tbl[a];
    pb = pos_tbl[b];
    held = subst_tbl[pa];
    subst_tbl[pa] = subst_tbl[pb];
    subst_tbl[pb] = held;
    pos_tbl[a] = pb;
    pos_tbl[b] = pa;
  endfunction

  function automatic xlate_result_t substitute_for(input letter_t a);
    xlate_result_t r;
    if (int'(a) >= ALPHABET_SIZE) begin
      r.letter  = '0;
      r.invalid = 1'b1;
    end else begin
      r.letter  = subst_tbl[a];
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        subst_tbl[i] = letter_t'(i);
        pos_tbl[i]   = letter_t'(i);
      end
      pending_xlates.delete();
      results_pending <= 0;
    end else begin
      // results first: a beat accepted now never belongs to an input of this edge
      if (out_ch.valid && out_ch.ready) begin
        if (pending_xlates.size() == 0) begin
          report($sformatf("result beat letter %0d invalid %0b with nothing expected",
                           out_ch.letter_out, out_ch.invalid));
        end else begin
          want = pending_xlates.pop_front();
          if (out_ch.letter_out !== want.letter) begin
            report($sformatf("letter_out %0d, expected %0d",
                             out_ch.letter_out, want.letter));
          end
          if (out_ch.invalid !== want.invalid) begin
            report($sformatf("invalid %0b, expected %0b", out_ch.invalid, want.invalid));
          end
          results_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_SWAP) begin
          apply_swap(in_ch.letter_a, in_ch.letter_b);
          swaps_seen++;
        end else begin
          pending_xlates.push_back(substitute_for(in_ch.letter_a));
          xlates_seen++;
        end
      end
      results_pending <= pending_xlates.size();
    end
  end

endmodule

// ===== verif/letter_permutation_swap_table_test.sv =====
// testbench top: stimulus, result back-pressure and verdict for the swap table
module letter_permutation_swap_table_test;
  import lps_pkg::*;

  localparam int RANDOM_BEATS = 1130;
  // worst case per beat is an idle gap, the busy swap states and a stalled result
  localparam int CYCLE_LIMIT  = 200000;
  // slowest operation is a swap, leave some margin
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   fail_count;
  int   results_pending;
  int   swaps_seen;
  int   xlates_seen;
  int   results_checked;

  // stretches of back-to-back beats alternate with stretches of random gaps
  bit   in_calm;
  bit   out_calm;
  int   in_beats;
  int   out_beats;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  letter_permutation_swap_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  letter_permutation_swap_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .swaps_seen      (swaps_seen),
    .xlates_seen     (xlates_seen),
    .results_checked (results_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("letter_permutation_swap_table_test: FAIL");
      $finish;
    end
  end

  // idle cycles before the next beat; a zero keeps valid or ready high
  function automatic int draw_gap(input bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // one input beat: optional idle gap, then hold until ready is seen high
  task automatic send_beat(input op_t op, input letter_t a, input letter_t b);
    int gap;
    if (in_beats % 64 == 0) begin
      in_calm = ($urandom_range(0, 3) == 0);
    end
    in_beats++;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.letter_a <= a;
    in_ch.letter_b <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // mostly in-alphabet codes so swaps build up a real permutation
  function automatic letter_t pick_letter();
    if ($urandom_range(0, 9) == 0) begin
      return letter_t'($urandom_range(ALPHABET_SIZE, 31));
    end
    return letter_t'($urandom_range(0, ALPHABET_SIZE - 1));
  endfunction

  // result side: random stalls between accepted result beats
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    out_beats    = 0;
    @(posedge clk);
    forever begin
      if (out_beats % 48 == 0) begin
        out_calm = ($urandom_range(0, 3) == 0);
      end
      out_beats++;
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    letter_t a;
    letter_t b;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_SWAP;
    in_ch.letter_a = '0;
    in_ch.letter_b = '0;
    in_beats       = 0;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity table, edges of the alphabet and codes past its end
    send_beat(OP_XLATE, 5'd0, 5'd31);
    send_beat(OP_XLATE, 5'd25, 5'd0);
    send_beat(OP_XLATE, 5'd26, 5'd26);
    send_beat(OP_XLATE, 5'd31, 5'd31);
    // swap of the two end letters, then read them back
    send_beat(OP_SWAP, 5'd0, 5'd25);
    send_beat(OP_XLATE, 5'd0, 5'd0);
    send_beat(OP_XLATE, 5'd25, 5'd0);
    // self swap leaves the table alone
    send_beat(OP_SWAP, 5'd7, 5'd7);
    send_beat(OP_XLATE, 5'd7, 5'd7);
    // swaps touching an out-of-range code are dropped
    send_beat(OP_SWAP, 5'd3, 5'd26);
    send_beat(OP_SWAP, 5'd31, 5'd3);
    send_beat(OP_SWAP, 5'd30, 5'd30);
    send_beat(OP_XLATE, 5'd3, 5'd31);
    // chained swaps: the second one must go through the inverse table
    send_beat(OP_SWAP, 5'd0, 5'd1);
    send_beat(OP_SWAP, 5'd25, 5'd1);
    send_beat(OP_XLATE, 5'd0, 5'd31);
    send_beat(OP_XLATE, 5'd1, 5'd0);
    send_beat(OP_XLATE, 5'd25, 5'd25);
    send_beat(OP_XLATE, 5'd31, 5'd0);

    // random mix: swaps with random letters, some self swaps, some bad codes, and translates
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      a = pick_letter();
      if ($urandom_range(0, 1) == 0) begin
        b = ($urandom_range(0, 19) == 0) ? a : pick_letter();
        send_beat(OP_SWAP, a, b);
      end else begin
        b = letter_t'($urandom_range(0, 31));
        send_beat(OP_XLATE, a, b);
      end
    end
    in_ch.valid <= 1'b0;

    // let every translate come out, then give the last swap time to settle
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d swap beats and %0d translate beats, %0d results compared",
             swaps_seen, xlates_seen, results_checked);
    $display("mismatches: %0d, cycles: %0d", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("letter_permutation_swap_table_test: PASS");
    end else begin
      $display("letter_permutation_swap_table_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== letter_permutation_swap_table.f =====
rtl/core/lps_pkg.sv
rtl/core/lps_if.sv
rtl/core/lps_ram.sv
rtl/core/lps_table.sv
rtl/core/letter_permutation_swap_table.sv
verif/letter_permutation_swap_table_checker.sv
verif/letter_permutation_swap_table_test.sv
